// ===== rtl/core/npr_pkg.sv =====
package npr_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned DistW  = 18;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned StepW  = 3;

  localparam logic [DistW-1:0] DistStart = '1;

  localparam logic [StepW-1:0] StepIdle   = 3'd0;
  localparam logic [StepW-1:0] StepScan   = 3'd1;
  localparam logic [StepW-1:0] StepDrain0 = 3'd2;
  localparam logic [StepW-1:0] StepDrain1 = 3'd3;
  localparam logic [StepW-1:0] StepEmit   = 3'd4;

  typedef enum logic {
    OpWrite = 1'b0,
    OpQuery = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CondNever   = 2'd0,
    CondAlways  = 2'd1,
    CondNoQuery = 2'd2,
    CondNotLast = 2'd3
  } cond_e;

  typedef struct packed {
    logic             op;
    logic [IdxW-1:0]  entry_index;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } cmd_t;

  typedef struct packed {
    logic [IdxW-1:0]  best_index;
    logic [DistW-1:0] best_distance;
    logic             exact_match;
  } res_t;

  typedef struct packed {
    logic idle;
    logic issue;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic query;
    logic scan_last;
  } stat_t;

  typedef struct packed {
    ctrl_t            ctrl;
    cond_e            cond;
    logic [StepW-1:0] target;
  } uword_t;

  function automatic uword_t ucode_rom(input logic [StepW-1:0] step);
    uword_t w;
    w = '{ctrl: '{idle: 1'b0, issue: 1'b0, emit: 1'b0}, cond: CondAlways, target: StepIdle};
    unique case (step)
      StepIdle: begin
        w.ctrl.idle = 1'b1;
        w.cond      = CondNoQuery;
        w.target    = StepIdle;
      end
      StepScan: begin
        w.ctrl.issue = 1'b1;
        w.cond       = CondNotLast;
        w.target     = StepScan;
      end
      StepDrain0: begin
        w.cond = CondNever;
      end
      StepDrain1: begin
        w.cond = CondNever;
      end
      StepEmit: begin
        w.ctrl.emit = 1'b1;
        w.cond      = CondAlways;
        w.target    = StepIdle;
      end
      default: begin
        w.cond   = CondAlways;
        w.target = StepIdle;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/nearest_palette_rgb.sv =====
// Nearest palette color, squared RGB distance.
// Command channel: cmd_i is taken at a rising edge with start_i high and
// busy_o low. op = write stores {red, green, blue} at entry_index (indexes at
// or above PALETTE_SIZE are dropped); it gives no result and busy_o stays low,
// so a new command can follow in the next cycle.
// op = query scans min(PALETTE_SIZE, 256) entries, one per cycle, through a
// single registered read port of the palette memory, then through a square
// stage and a sum-and-compare stage. The result transfer comes as a one-cycle
// valid_o strobe with res_o, and busy_o drops the cycle after.
// On a tie the lowest index is kept. exact_match flags a distance of zero.
// The receiver cannot stall: res_o holds until the next query is accepted.
// Reset returns the sequencer to idle; the palette is not cleared, and each
// entry must be written before a query reads it.
module nearest_palette_rgb #(
  parameter int unsigned PALETTE_SIZE = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  npr_pkg::cmd_t  cmd_i,
  output logic           valid_o,
  output npr_pkg::res_t  res_o
);
  import npr_pkg::*;

  localparam int unsigned Depth = (PALETTE_SIZE < 256) ? PALETTE_SIZE : 256;

  ctrl_t ctrl;
  stat_t stat;

  npr_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  npr_datapath #(
    .Depth (Depth)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_i   (cmd_i),
    .ctrl_i  (ctrl),
    .stat_o  (stat),
    .res_o   (res_o)
  );

  assign busy_o  = ~ctrl.idle;
  assign valid_o = ctrl.emit;

endmodule

// ===== rtl/core/npr_useq.sv =====
module npr_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  npr_pkg::stat_t  stat_i,
  output npr_pkg::ctrl_t  ctrl_o
);
  import npr_pkg::*;

  logic [StepW-1:0] pc_q, pc_d;
  uword_t           uword;
  logic             take;

  assign uword  = ucode_rom(pc_q);
  assign ctrl_o = uword.ctrl;

  always_comb begin
    unique case (uword.cond)
      CondNever:   take = 1'b0;
      CondAlways:  take = 1'b1;
      CondNoQuery: take = ~stat_i.query;
      CondNotLast: take = ~stat_i.scan_last;
      default:     take = 1'b1;
    endcase
  end

  always_comb begin
    pc_d = take ? uword.target : pc_q + StepW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StepIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== rtl/core/npr_datapath.sv =====
module npr_datapath #(
  parameter int unsigned Depth = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  npr_pkg::cmd_t   cmd_i,
  input  npr_pkg::ctrl_t  ctrl_i,
  output npr_pkg::stat_t  stat_o,
  output npr_pkg::res_t   res_o
);
  import npr_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [3*ChanW-1:0] mem [Depth];

  logic                accept, wr_en, q_load;
  logic [ChanW-1:0]    qr_q, qg_q, qb_q;
  logic [AddrW-1:0]    addr_q;
  logic [3*ChanW-1:0]  rd_q;
  logic                rd_vld_q;
  logic [AddrW-1:0]    rd_idx_q;
  logic [2*ChanW-1:0]  sqr_q, sqg_q, sqb_q;
  logic [2*ChanW-1:0]  sqr_d, sqg_d, sqb_d;
  logic                sq_vld_q;
  logic [AddrW-1:0]    sq_idx_q;
  logic [DistW-1:0]    best_d_q;
  logic [AddrW-1:0]    best_i_q;
  logic [DistW-1:0]    dist_sum;
  logic                better;

  function automatic logic [2*ChanW-1:0] sq_diff(input logic [ChanW-1:0] a,
                                                 input logic [ChanW-1:0] b);
    logic [ChanW-1:0] d;
    d = (a > b) ? a - b : b - a;
    return (2*ChanW)'(d) * (2*ChanW)'(d);
  endfunction

  assign accept = start_i & ctrl_i.idle;
  assign wr_en  = accept & (cmd_i.op == OpWrite)
                & ({1'b0, cmd_i.entry_index} < (IdxW+1)'(Depth));
  assign q_load = accept & (cmd_i.op == OpQuery);

  assign stat_o.query     = start_i & (cmd_i.op == OpQuery);
  assign stat_o.scan_last = (addr_q == AddrW'(Depth - 1));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cmd_i.entry_index[AddrW-1:0]] <= {cmd_i.red, cmd_i.green, cmd_i.blue};
    end
    if (ctrl_i.issue) begin
      rd_q <= mem[addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_load) begin
      qr_q <= cmd_i.red;
      qg_q <= cmd_i.green;
      qb_q <= cmd_i.blue;
    end
    if (ctrl_i.issue) begin
      rd_idx_q <= addr_q;
    end
    if (rd_vld_q) begin
      sqr_q    <= sqr_d;
      sqg_q    <= sqg_d;
      sqb_q    <= sqb_d;
      sq_idx_q <= rd_idx_q;
    end
  end

  assign sqr_d = sq_diff(qr_q, rd_q[3*ChanW-1:2*ChanW]);
  assign sqg_d = sq_diff(qg_q, rd_q[2*ChanW-1:ChanW]);
  assign sqb_d = sq_diff(qb_q, rd_q[ChanW-1:0]);

  assign dist_sum = DistW'(sqr_q) + DistW'(sqg_q) + DistW'(sqb_q);
  assign better   = sq_vld_q & (dist_sum < best_d_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
      sq_vld_q <= 1'b0;
      best_d_q <= DistStart;
      best_i_q <= '0;
    end else begin
      rd_vld_q <= ctrl_i.issue;
      sq_vld_q <= rd_vld_q;
      if (q_load) begin
        addr_q   <= '0;
        best_d_q <= DistStart;
        best_i_q <= '0;
      end else begin
        if (ctrl_i.issue) begin
          addr_q <= addr_q + AddrW'(1);
        end
        if (better) begin
          best_d_q <= dist_sum;
          best_i_q <= sq_idx_q;
        end
      end
    end
  end

  assign res_o.best_index    = IdxW'(best_i_q);
  assign res_o.best_distance = best_d_q;
  assign res_o.exact_match   = (best_d_q == '0);

endmodule

// ===== tb/sv/nearest_palette_rgb_tb.sv =====
module nearest_palette_rgb_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import npr_pkg::*;

  typedef struct {
    cmd_t cmd;
    bit   known;
    res_t res;
  } dir_row_t;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  cmd_t cmd_i   = '0;
  logic busy_o;
  logic valid_o;
  res_t res_o;

  logic [3*ChanW-1:0] palette_shadow [256];
  res_t               nearest_due [$];
  res_t               due_res;
  int unsigned        fail_count = 0;
  bit                 no_idle    = 1'b0;

  nearest_palette_rgb u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_i   (cmd_i),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic res_t nearest_entry(input logic [ChanW-1:0] r, input logic [ChanW-1:0] g,
                                         input logic [ChanW-1:0] b);
    res_t        res;
    int          dr;
    int          dg;
    int          db;
    int unsigned dist_v;
    int unsigned best_d;
    int unsigned best_i;
    best_d = 32'h7fff_ffff;
    best_i = 0;
    for (int i = 0; i < 256; i++) begin
      dr     = int'(r) - int'(palette_shadow[i][23:16]);
      dg     = int'(g) - int'(palette_shadow[i][15:8]);
      db     = int'(b) - int'(palette_shadow[i][7:0]);
      dist_v = dr * dr + dg * dg + db * db;
      if (dist_v < best_d) begin
        best_d = dist_v;
        best_i = i;
      end
    end
    res.best_index    = best_i[IdxW-1:0];
    res.best_distance = best_d[DistW-1:0];
    res.exact_match   = (best_d == 0);
    return res;
  endfunction

  function automatic logic [ChanW-1:0] nudge(input logic [ChanW-1:0] v);
    int t;
    t = int'(v) + int'($urandom_range(0, 8)) - 4;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return t[ChanW-1:0];
  endfunction

  function automatic dir_row_t mk_row(input op_e op, input logic [IdxW-1:0] idx,
                                      input logic [ChanW-1:0] r, input logic [ChanW-1:0] g,
                                      input logic [ChanW-1:0] b, input bit known,
                                      input logic [IdxW-1:0] bi, input logic [DistW-1:0] bd,
                                      input logic em);
    dir_row_t row;
    row.cmd.op                = op;
    row.cmd.entry_index       = idx;
    row.cmd.red               = r;
    row.cmd.green             = g;
    row.cmd.blue              = b;
    row.known                 = known;
    row.res.best_index        = bi;
    row.res.best_distance     = bd;
    row.res.exact_match       = em;
    return row;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_cmd(input dir_row_t item);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i = 1'b1;
    cmd_i   = item.cmd;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    if (item.cmd.op == OpWrite) begin
      palette_shadow[item.cmd.entry_index] = {item.cmd.red, item.cmd.green, item.cmd.blue};
    end else begin
      nearest_due.push_back(item.known ? item.res :
                            nearest_entry(item.cmd.red, item.cmd.green, item.cmd.blue));
    end
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o === 1'b1) begin
      if (nearest_due.size() == 0) begin
        $error("result transfer with none pending: best_index %0d", res_o.best_index);
        fail_count++;
      end else begin
        due_res = nearest_due.pop_front();
        if (res_o.best_index !== due_res.best_index) begin
          $error("best_index: expected %0d, got %0d", due_res.best_index, res_o.best_index);
          fail_count++;
        end
        if (res_o.best_distance !== due_res.best_distance) begin
          $error("best_distance: expected %0d, got %0d",
                 due_res.best_distance, res_o.best_distance);
          fail_count++;
        end
        if (res_o.exact_match !== due_res.exact_match) begin
          $error("exact_match: expected %0b, got %0b", due_res.exact_match, res_o.exact_match);
          fail_count++;
        end
      end
    end
  end

  initial begin
    dir_row_t    directed_rows [$];
    dir_row_t    item;
    int unsigned pick;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // load every slot before the first query
    for (int i = 0; i < 256; i++) begin
      send_cmd(mk_row(OpWrite, i[IdxW-1:0], 8'd255, 8'd255, 8'd255, 1'b0, '0, '0, 1'b0));
    end

    directed_rows.push_back(mk_row(OpQuery, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 18'd195075, 1'b0));
    directed_rows.push_back(mk_row(OpQuery, 8'd255, 8'd255, 8'd255, 8'd255,
                                   1'b1, 8'd0, 18'd0, 1'b1));
    directed_rows.push_back(mk_row(OpWrite, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(OpQuery, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd255, 18'd0, 1'b1));
    directed_rows.push_back(mk_row(OpQuery, 8'd0, 8'd1, 8'd0, 8'd0, 1'b1, 8'd255, 18'd1, 1'b0));
    directed_rows.push_back(mk_row(OpWrite, 8'd17, 8'd0, 8'd0, 8'd0, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(OpQuery, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd17, 18'd0, 1'b1));
    directed_rows.push_back(mk_row(OpWrite, 8'd3, 8'd0, 8'd0, 8'd1, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(OpQuery, 8'd0, 8'd0, 8'd0, 8'd2, 1'b1, 8'd3, 18'd1, 1'b0));
    directed_rows.push_back(mk_row(OpQuery, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd17, 18'd0, 1'b1));
    directed_rows.push_back(mk_row(OpWrite, 8'd0, 8'd128, 8'd64, 8'd32, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(OpQuery, 8'd0, 8'd128, 8'd64, 8'd32, 1'b1, 8'd0, 18'd0, 1'b1));
    directed_rows.push_back(mk_row(OpQuery, 8'd0, 8'd130, 8'd60, 8'd40, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(OpWrite, 8'd254, 8'd255, 8'd0, 8'd0, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(OpQuery, 8'd0, 8'd255, 8'd0, 8'd0, 1'b1, 8'd254, 18'd0, 1'b1));
    directed_rows.push_back(mk_row(OpQuery, 8'd0, 8'd200, 8'd10, 8'd10, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(OpWrite, 8'd1, 8'd0, 8'd255, 8'd0, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(OpQuery, 8'd0, 8'd0, 8'd255, 8'd0, 1'b1, 8'd1, 18'd0, 1'b1));
    directed_rows.push_back(mk_row(OpQuery, 8'd0, 8'd0, 8'd200, 8'd0, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(OpWrite, 8'd2, 8'd0, 8'd0, 8'd255, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(OpQuery, 8'd0, 8'd0, 8'd0, 8'd255, 1'b1, 8'd2, 18'd0, 1'b1));
    directed_rows.push_back(mk_row(OpQuery, 8'd0, 8'd255, 8'd255, 8'd0, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(OpQuery, 8'd0, 8'd127, 8'd127, 8'd127, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(OpWrite, 8'd3, 8'd255, 8'd255, 8'd255, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(OpQuery, 8'd0, 8'd0, 8'd0, 8'd1, 1'b0, '0, '0, 1'b0));

    foreach (directed_rows[k]) begin
      send_cmd(directed_rows[k]);
    end

    for (int n = 0; n < 270; n++) begin
      if (n % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
      item       = mk_row(OpWrite, '0, '0, '0, '0, 1'b0, '0, '0, 1'b0);
      item.cmd.op          = ($urandom_range(0, 99) < 45) ? OpQuery : OpWrite;
      item.cmd.entry_index = IdxW'($urandom_range(0, 255));
      pick = $urandom_range(0, 9);
      if (item.cmd.op == OpWrite) begin
        // duplicate an existing color now and then to set up ties
        if (pick < 3) begin
          {item.cmd.red, item.cmd.green, item.cmd.blue} =
            palette_shadow[IdxW'($urandom_range(0, 255))];
        end else begin
          {item.cmd.red, item.cmd.green, item.cmd.blue} = (3*ChanW)'($urandom);
        end
      end else if (pick < 5) begin
        {item.cmd.red, item.cmd.green, item.cmd.blue} =
          palette_shadow[IdxW'($urandom_range(0, 255))];
        if (pick >= 3) begin
          item.cmd.red   = nudge(item.cmd.red);
          item.cmd.green = nudge(item.cmd.green);
          item.cmd.blue  = nudge(item.cmd.blue);
        end
      end else begin
        {item.cmd.red, item.cmd.green, item.cmd.blue} = (3*ChanW)'($urandom);
      end
      send_cmd(item);
    end

    start_i = 1'b0;
    while (nearest_due.size() != 0) @(posedge clk_i);
    repeat (270) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
